/* hdl/tgp_pkg.sv */
// Shared types, widths and operation codes for the triangle predicate pipeline.
// No dependencies; imported by every module of the block.
package tgp_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int FRAC_BITS    = 8;
    localparam int CENTER_WIDTH = 48;
    localparam int CLAMP_LOG    = 50;

    // difference, product, cross/orientation widths
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int OW   = PW + 1;
    // in-circle determinant
    localparam int DETW = 2 * OW + 2;
    // circumcenter numerator, scaled numerator, denominator
    localparam int NW   = DW + OW + 1;
    localparam int NUMW = NW + FRAC_BITS + 3;
    localparam int QW   = NUMW;
    localparam int DENW = OW + 2;
    // post-divide working width
    localparam int WW   = ((QW > CLAMP_LOG + 1) ? QW : CLAMP_LOG + 1) + 2;

    localparam int PRE_STAGES  = 7;
    localparam int LANE_STAGES = QW + 3;
    localparam int PIPE_STAGES = PRE_STAGES + LANE_STAGES;

    localparam logic [WW-1:0] QUO_LIM =
        {{(WW - CLAMP_LOG - 1){1'b0}}, 1'b1, {CLAMP_LOG{1'b0}}};
    localparam logic signed [WW-1:0] CTR_MAX =
        {{(WW - CENTER_WIDTH + 1){1'b0}}, {(CENTER_WIDTH - 1){1'b1}}};
    localparam logic signed [WW-1:0] CTR_MIN =
        {{(WW - CENTER_WIDTH + 1){1'b1}}, {(CENTER_WIDTH - 1){1'b0}}};

    localparam logic [1:0] OP_INCIRCLE = 2'd0;
    localparam logic [1:0] OP_CENTER   = 2'd1;
    localparam logic [1:0] OP_INSIDE   = 2'd2;
    localparam logic [1:0] OP_ORIENT   = 2'd3;

    typedef struct packed {
        logic answer;
        logic degenerate;
        logic keep;
    } side_t;

    function automatic logic signed [PW-1:0] smul_d(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
        smul_d = a * b;
    endfunction

endpackage

/* hdl/tgp_lane.sv */
// One circumcenter coordinate lane: pipelined restoring divider, floor fix,
// clamp, base offset and 48-bit saturation. Depends on tgp_pkg.
module tgp_lane
    import tgp_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [QW-1:0]                  mag,
    input  logic                           neg,
    input  logic [DENW-1:0]                den,
    input  logic signed [COORD_WIDTH-1:0]  base,
    output logic signed [CENTER_WIDTH-1:0] center
);

    logic [DENW-1:0]              rem_reg  [QW];
    logic [QW-1:0]                nq_reg   [QW];
    logic [DENW-1:0]              den_reg  [QW];
    logic                         neg_reg  [QW];
    logic signed [COORD_WIDTH-1:0] base_reg [QW];

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DENW-1:0]               rem_prev;
        logic [DENW-1:0]               den_prev;
        logic [QW-1:0]                 nq_prev;
        logic                          neg_prev;
        logic signed [COORD_WIDTH-1:0] base_prev;
        logic [DENW:0]                 trial;
        logic [DENW:0]                 diff;
        logic                          fits;
        logic [DENW-1:0]               rem_next;
        logic [QW-1:0]                 nq_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign den_prev  = den;
            assign nq_prev   = mag;
            assign neg_prev  = neg;
            assign base_prev = base;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign nq_prev   = nq_reg[k-1];
            assign neg_prev  = neg_reg[k-1];
            assign base_prev = base_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_prev, nq_prev[QW-1]};
            diff     = trial - {1'b0, den_prev};
            fits     = trial >= {1'b0, den_prev};
            rem_next = fits ? diff[DENW-1:0] : trial[DENW-1:0];
            nq_next  = {nq_prev[QW-2:0], fits};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                den_reg[k]  <= den_prev;
                neg_reg[k]  <= neg_prev;
                base_reg[k] <= base_prev;
            end
        end
    end

    logic [WW-1:0]                 qa_reg;
    logic [WW-1:0]                 qa_next;
    logic                          p1_neg_reg;
    logic signed [COORD_WIDTH-1:0] p1_base_reg;
    logic signed [WW-1:0]          sv_reg;
    logic signed [WW-1:0]          sv_next;
    logic signed [COORD_WIDTH-1:0] p2_base_reg;
    logic signed [CENTER_WIDTH-1:0] center_reg;
    logic signed [CENTER_WIDTH-1:0] center_next;

    // floor for negative numerators rounds the magnitude up
    always_comb
    begin
        qa_next = WW'(nq_reg[QW-1]) + WW'(neg_reg[QW-1] && (|rem_reg[QW-1]));
        if (qa_next > QUO_LIM)
            qa_next = QUO_LIM;
    end

    always_comb
    begin
        sv_next = p1_neg_reg ? -$signed(qa_reg) : $signed(qa_reg);
    end

    always_comb
    begin
        logic signed [WW-1:0] v;
        v = sv_reg + (WW'(p2_base_reg) <<< FRAC_BITS);
        if (v > CTR_MAX)
            v = CTR_MAX;
        else if (v < CTR_MIN)
            v = CTR_MIN;
        center_next = v[CENTER_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg      <= qa_next;
            p1_neg_reg  <= neg_reg[QW-1];
            p1_base_reg <= base_reg[QW-1];
            sv_reg      <= sv_next;
            p2_base_reg <= p1_base_reg;
            center_reg  <= center_next;
        end
    end

    assign center = center_reg;

endmodule

/* hdl/triangle_geometry_predicates.sv */
// Top level of the triangle predicate pipeline: in-circle, circumcenter,
// point-in-triangle and orientation. Depends on tgp_pkg and tgp_lane.

// One transaction enters per clock and one result transaction leaves per clock
// while the pipe is not stalled. Every operation passes through all PIPE_STAGES
// stages from acceptance to out_valid (7 geometry stages, one stage per quotient
// bit of the 64-bit circumcenter divider, then 3 rounding/saturation stages). The
// depth is set by the bit-serial divider, which every transaction passes
// through so that results stay in order. The whole pipe advances together:
// in_stall is high only while a result sits in the output register and the
// consumer holds out_stall. center_x/center_y are signed fixed point with
// FRAC_BITS fraction bits, rounded to nearest (ties up) and saturated to 48
// bits; they read zero for every operation other than circumcenter and for
// collinear vertices, which raise degenerate.
module triangle_geometry_predicates
    import tgp_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic signed [COORD_WIDTH-1:0]  vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0]  vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0]  vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0]  vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0]  vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0]  vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0]  query_x,
    input  logic signed [COORD_WIDTH-1:0]  query_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           answer,
    output logic signed [CENTER_WIDTH-1:0] center_x,
    output logic signed [CENTER_WIDTH-1:0] center_y,
    output logic                           degenerate
);

    logic                   en;
    logic [PIPE_STAGES-1:0] vld_reg;

    // global advance: only a held result at the output freezes the pipe
    assign en       = !(vld_reg[PIPE_STAGES-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], in_valid};
    end

    // ---- stage 1: coordinate differences ----
    logic [1:0]                    s1_op_reg;
    logic signed [COORD_WIDTH-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [DW-1:0] s1_ux_reg, s1_uy_reg, s1_vx_reg, s1_vy_reg, s1_wx_reg, s1_wy_reg;
    logic signed [DW-1:0] s1_adx_reg, s1_ady_reg, s1_bdx_reg, s1_bdy_reg;
    logic signed [DW-1:0] s1_cdx_reg, s1_cdy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg  <= operation;
            s1_ax_reg  <= vertex_a_x;
            s1_ay_reg  <= vertex_a_y;
            s1_ux_reg  <= DW'(vertex_b_x) - DW'(vertex_a_x);
            s1_uy_reg  <= DW'(vertex_b_y) - DW'(vertex_a_y);
            s1_vx_reg  <= DW'(vertex_c_x) - DW'(vertex_a_x);
            s1_vy_reg  <= DW'(vertex_c_y) - DW'(vertex_a_y);
            s1_wx_reg  <= DW'(vertex_c_x) - DW'(vertex_b_x);
            s1_wy_reg  <= DW'(vertex_c_y) - DW'(vertex_b_y);
            s1_adx_reg <= DW'(vertex_a_x) - DW'(query_x);
            s1_ady_reg <= DW'(vertex_a_y) - DW'(query_y);
            s1_bdx_reg <= DW'(vertex_b_x) - DW'(query_x);
            s1_bdy_reg <= DW'(vertex_b_y) - DW'(query_y);
            s1_cdx_reg <= DW'(vertex_c_x) - DW'(query_x);
            s1_cdy_reg <= DW'(vertex_c_y) - DW'(query_y);
        end
    end

    // ---- stage 2: 2x2 cross products and squared lengths ----
    logic [1:0]                    s2_op_reg;
    logic signed [COORD_WIDTH-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [DW-1:0]          s2_ux_reg, s2_uy_reg, s2_vx_reg, s2_vy_reg;
    logic signed [OW-1:0] s2_orient_reg, s2_e1_reg, s2_e2_reg, s2_e3_reg;
    logic signed [OW-1:0] s2_u2_reg, s2_v2_reg, s2_a2_reg, s2_b2_reg, s2_c2_reg;
    logic signed [OW-1:0] s2_xa_reg, s2_xb_reg, s2_xc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg <= s1_op_reg;
            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
            s2_ux_reg <= s1_ux_reg;
            s2_uy_reg <= s1_uy_reg;
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_orient_reg <= OW'(smul_d(s1_ux_reg, s1_vy_reg))
                           - OW'(smul_d(s1_uy_reg, s1_vx_reg));
            // edge functions, same sign as the query-minus-vertex form
            s2_e1_reg <= OW'(smul_d(s1_uy_reg, s1_adx_reg))
                       - OW'(smul_d(s1_ux_reg, s1_ady_reg));
            s2_e2_reg <= OW'(smul_d(s1_wy_reg, s1_bdx_reg))
                       - OW'(smul_d(s1_wx_reg, s1_bdy_reg));
            s2_e3_reg <= OW'(smul_d(s1_vx_reg, s1_cdy_reg))
                       - OW'(smul_d(s1_vy_reg, s1_cdx_reg));
            s2_u2_reg <= OW'(smul_d(s1_ux_reg, s1_ux_reg))
                       + OW'(smul_d(s1_uy_reg, s1_uy_reg));
            s2_v2_reg <= OW'(smul_d(s1_vx_reg, s1_vx_reg))
                       + OW'(smul_d(s1_vy_reg, s1_vy_reg));
            s2_a2_reg <= OW'(smul_d(s1_adx_reg, s1_adx_reg))
                       + OW'(smul_d(s1_ady_reg, s1_ady_reg));
            s2_b2_reg <= OW'(smul_d(s1_bdx_reg, s1_bdx_reg))
                       + OW'(smul_d(s1_bdy_reg, s1_bdy_reg));
            s2_c2_reg <= OW'(smul_d(s1_cdx_reg, s1_cdx_reg))
                       + OW'(smul_d(s1_cdy_reg, s1_cdy_reg));
            s2_xa_reg <= OW'(smul_d(s1_bdx_reg, s1_cdy_reg))
                       - OW'(smul_d(s1_cdx_reg, s1_bdy_reg));
            s2_xb_reg <= OW'(smul_d(s1_cdx_reg, s1_ady_reg))
                       - OW'(smul_d(s1_adx_reg, s1_cdy_reg));
            s2_xc_reg <= OW'(smul_d(s1_adx_reg, s1_bdy_reg))
                       - OW'(smul_d(s1_bdx_reg, s1_ady_reg));
        end
    end

    // ---- stage 3: determinant terms, center numerator terms, simple tests ----
    logic                          s2_oneg;
    logic                          s2_inside;
    logic                          s3_pre_next;

    assign s2_oneg   = s2_orient_reg < 0;
    assign s2_inside = s2_oneg ? (s2_e1_reg <= 0 && s2_e2_reg <= 0 && s2_e3_reg <= 0)
                               : (s2_e1_reg >= 0 && s2_e2_reg >= 0 && s2_e3_reg >= 0);

    always_comb
    begin
        case (s2_op_reg)
            OP_INSIDE: s3_pre_next = s2_inside;
            OP_ORIENT: s3_pre_next = s2_oneg;
            default:   s3_pre_next = 1'b0;
        endcase
    end

    logic [1:0]                    s3_op_reg;
    logic signed [COORD_WIDTH-1:0] s3_ax_reg, s3_ay_reg;
    logic                          s3_oneg_reg, s3_degen_reg, s3_pre_reg;
    logic [OW-1:0]                 s3_abso_reg;
    logic signed [2*OW-1:0]        s3_da_reg, s3_db_reg, s3_dc_reg;
    logic signed [DW+OW-1:0]       s3_t1_reg, s3_t2_reg, s3_t3_reg, s3_t4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_ax_reg    <= s2_ax_reg;
            s3_ay_reg    <= s2_ay_reg;
            s3_oneg_reg  <= s2_oneg;
            s3_degen_reg <= s2_orient_reg == 0;
            s3_pre_reg   <= s3_pre_next;
            s3_abso_reg  <= s2_oneg ? OW'(-s2_orient_reg) : OW'(s2_orient_reg);
            s3_da_reg    <= s2_a2_reg * s2_xa_reg;
            s3_db_reg    <= s2_b2_reg * s2_xb_reg;
            s3_dc_reg    <= s2_c2_reg * s2_xc_reg;
            s3_t1_reg    <= s2_vy_reg * s2_u2_reg;
            s3_t2_reg    <= s2_uy_reg * s2_v2_reg;
            s3_t3_reg    <= s2_ux_reg * s2_v2_reg;
            s3_t4_reg    <= s2_vx_reg * s2_u2_reg;
        end
    end

    // ---- stage 4: sums ----
    logic [1:0]                    s4_op_reg;
    logic signed [COORD_WIDTH-1:0] s4_ax_reg, s4_ay_reg;
    logic                          s4_oneg_reg, s4_degen_reg, s4_pre_reg;
    logic [OW-1:0]                 s4_abso_reg;
    logic signed [DETW-1:0]        s4_det_reg;
    logic signed [NW-1:0]          s4_nx_reg, s4_ny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_op_reg    <= s3_op_reg;
            s4_ax_reg    <= s3_ax_reg;
            s4_ay_reg    <= s3_ay_reg;
            s4_oneg_reg  <= s3_oneg_reg;
            s4_degen_reg <= s3_degen_reg;
            s4_pre_reg   <= s3_pre_reg;
            s4_abso_reg  <= s3_abso_reg;
            s4_det_reg   <= DETW'(s3_da_reg) + DETW'(s3_db_reg) + DETW'(s3_dc_reg);
            s4_nx_reg    <= NW'(s3_t1_reg) - NW'(s3_t2_reg);
            s4_ny_reg    <= NW'(s3_t3_reg) - NW'(s3_t4_reg);
        end
    end

    // ---- stage 5: in-circle decision, numerator sign follows orientation ----
    side_t s5_side_next;

    always_comb
    begin
        s5_side_next.degenerate = s4_degen_reg;
        s5_side_next.keep       = (s4_op_reg == OP_CENTER) && !s4_degen_reg;
        if (s4_op_reg == OP_INCIRCLE)
            s5_side_next.answer = !s4_degen_reg
                && ((s4_det_reg == 0) || ((s4_det_reg < 0) == s4_oneg_reg));
        else
            s5_side_next.answer = s4_pre_reg;
    end

    side_t                         s5_side_reg;
    logic signed [COORD_WIDTH-1:0] s5_ax_reg, s5_ay_reg;
    logic [OW-1:0]                 s5_abso_reg;
    logic signed [NW:0]            s5_nx_reg, s5_ny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s5_side_next;
            s5_ax_reg   <= s4_ax_reg;
            s5_ay_reg   <= s4_ay_reg;
            s5_abso_reg <= s4_abso_reg;
            s5_nx_reg   <= s4_oneg_reg ? -(NW+1)'(s4_nx_reg) : (NW+1)'(s4_nx_reg);
            s5_ny_reg   <= s4_oneg_reg ? -(NW+1)'(s4_ny_reg) : (NW+1)'(s4_ny_reg);
        end
    end

    // ---- stage 6: scaled numerator plus half denominator for rounding ----
    side_t                         s6_side_reg;
    logic signed [COORD_WIDTH-1:0] s6_ax_reg, s6_ay_reg;
    logic [DENW-1:0]               s6_den_reg;
    logic signed [NUMW-1:0]        s6_numx_reg, s6_numy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg <= s5_side_reg;
            s6_ax_reg   <= s5_ax_reg;
            s6_ay_reg   <= s5_ay_reg;
            s6_den_reg  <= {s5_abso_reg, 2'b00};
            s6_numx_reg <= (NUMW'(s5_nx_reg) <<< (FRAC_BITS + 1))
                         + $signed(NUMW'({s5_abso_reg, 1'b0}));
            s6_numy_reg <= (NUMW'(s5_ny_reg) <<< (FRAC_BITS + 1))
                         + $signed(NUMW'({s5_abso_reg, 1'b0}));
        end
    end

    // ---- stage 7: sign and magnitude for the unsigned divider ----
    side_t                         s7_side_reg;
    logic signed [COORD_WIDTH-1:0] s7_ax_reg, s7_ay_reg;
    logic [DENW-1:0]               s7_den_reg;
    logic                          s7_negx_reg, s7_negy_reg;
    logic [QW-1:0]                 s7_magx_reg, s7_magy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_side_reg <= s6_side_reg;
            s7_ax_reg   <= s6_ax_reg;
            s7_ay_reg   <= s6_ay_reg;
            s7_den_reg  <= s6_den_reg;
            s7_negx_reg <= s6_numx_reg < 0;
            s7_negy_reg <= s6_numy_reg < 0;
            s7_magx_reg <= (s6_numx_reg < 0) ? QW'(-s6_numx_reg) : QW'(s6_numx_reg);
            s7_magy_reg <= (s6_numy_reg < 0) ? QW'(-s6_numy_reg) : QW'(s6_numy_reg);
        end
    end

    // ---- divider lanes, flags ride alongside ----
    logic signed [CENTER_WIDTH-1:0] lane_x, lane_y;

    tgp_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .mag    (s7_magx_reg),
        .neg    (s7_negx_reg),
        .den    (s7_den_reg),
        .base   (s7_ax_reg),
        .center (lane_x)
    );

    tgp_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .mag    (s7_magy_reg),
        .neg    (s7_negy_reg),
        .den    (s7_den_reg),
        .base   (s7_ay_reg),
        .center (lane_y)
    );

    side_t side_reg [LANE_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s7_side_reg;
            for (int i = 1; i < LANE_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign out_valid  = vld_reg[PIPE_STAGES-1];
    assign answer     = side_reg[LANE_STAGES-1].answer;
    assign degenerate = side_reg[LANE_STAGES-1].degenerate;
    assign center_x   = side_reg[LANE_STAGES-1].keep ? lane_x : '0;
    assign center_y   = side_reg[LANE_STAGES-1].keep ? lane_y : '0;

endmodule

/* hdl/tgp_checker.sv */
// Port-level checks for triangle_geometry_predicates, attached by bind.
// Depends on tgp_pkg.
module tgp_checker
    import tgp_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           answer,
    input logic signed [CENTER_WIDTH-1:0] center_x,
    input logic signed [CENTER_WIDTH-1:0] center_y,
    input logic                           degenerate
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(center_x) && $stable(center_y)
                                   && $stable(answer) && $stable(degenerate))
        else $error("held result changed");

    // input backpressure only from a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_degen_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> center_x == 0 && center_y == 0)
        else $error("center reported for collinear vertices");

    a_center_answer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (center_x != 0 || center_y != 0) |-> !answer && !degenerate)
        else $error("center transaction with answer or degenerate set");

endmodule

bind triangle_geometry_predicates tgp_checker u_tgp_checker (.*);
